>>> rtl/core/rpbh_pkg.sv
package rpbh_pkg;

	// operation codes
	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_POINT = 2'd1;
	localparam logic [1:0] OP_RAY   = 2'd2;
	localparam logic [1:0] OP_NONE  = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_ROW_COUNT    = 2'd0;
	localparam logic [1:0] CFG_SEARCH_UPPER = 2'd1;
	localparam logic [1:0] CFG_TOLERANCE    = 2'd2;

	localparam logic [47:0] SEARCH_UPPER_RST = 48'd65536000000000;
	localparam logic [15:0] TOLERANCE_RST    = 16'd66;

	typedef struct packed {
		logic [1:0]         op;
		logic [3:0]         row_index;
		logic signed [31:0] normal_x;
		logic signed [31:0] normal_y;
		logic signed [31:0] normal_z;
		logic signed [31:0] bound;
		logic signed [31:0] start_x;
		logic signed [31:0] start_y;
		logic signed [31:0] start_z;
		logic signed [31:0] dir_x;
		logic signed [31:0] dir_y;
		logic signed [31:0] dir_z;
	} item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TEST_START,
		ST_CHECK,
		ST_ADV_MID,
		ST_TEST_MID,
		ST_ADV_FIN,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic test_done;
		logic test_in;
		logic adv_done;
		logic pop_ready;
		logic out_load;
	} ctl_t;

endpackage

>>> rtl/core/rpbh_if.sv
interface rpbh_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         op;
	logic [3:0]         row_index;
	logic signed [31:0] normal_x;
	logic signed [31:0] normal_y;
	logic signed [31:0] normal_z;
	logic signed [31:0] bound;
	logic signed [31:0] start_x;
	logic signed [31:0] start_y;
	logic signed [31:0] start_z;
	logic signed [31:0] dir_x;
	logic signed [31:0] dir_y;
	logic signed [31:0] dir_z;
	modport source (output valid, op, row_index, normal_x, normal_y, normal_z, bound,
		start_x, start_y, start_z, dir_x, dir_y, dir_z, input ready);
	modport sink (input valid, op, row_index, normal_x, normal_y, normal_z, bound,
		start_x, start_y, start_z, dir_x, dir_y, dir_z, output ready);
endinterface

interface rpbh_rsp_if;
	logic               valid;
	logic               ready;
	logic               inside_res;
	logic signed [31:0] hit_x;
	logic signed [31:0] hit_y;
	logic signed [31:0] hit_z;
	logic [47:0]        hit_param;
	modport source (output valid, inside_res, hit_x, hit_y, hit_z, hit_param, input ready);
	modport sink (input valid, inside_res, hit_x, hit_y, hit_z, hit_param, output ready);
endinterface

interface rpbh_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [47:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/rpbh_front.sv
module rpbh_front (
	input  logic               clk,
	input  logic               arst_n,
	rpbh_req_if.sink           req,
	output logic               push_valid,
	input  logic               push_ready,
	output rpbh_pkg::item_t    push_item
);

	logic            valid_s1;
	rpbh_pkg::item_t item_s1;

	assign req.ready  = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_item  = item_s1;

	// unused op is dropped here, it has no effect
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid && (req.op != rpbh_pkg::OP_NONE);
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			item_s1 <= '{op: req.op, row_index: req.row_index,
				normal_x: req.normal_x, normal_y: req.normal_y, normal_z: req.normal_z,
				bound: req.bound, start_x: req.start_x, start_y: req.start_y,
				start_z: req.start_z, dir_x: req.dir_x, dir_y: req.dir_y, dir_z: req.dir_z};
		end
	end

endmodule

>>> rtl/core/rpbh_queue.sv
module rpbh_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  rpbh_pkg::item_t push_item,
	output logic            pop_valid,
	input  logic            pop_ready,
	output rpbh_pkg::item_t pop_item
);

	rpbh_pkg::item_t slot_q [2];
	logic            wr_q;
	logic            rd_q;
	logic [1:0]      cnt_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_item   = slot_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wr_q <= !wr_q;
			if (do_pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_q] <= push_item;
	end

endmodule

>>> rtl/core/rpbh_back.sv
module rpbh_back #(
	parameter int MAX_ROWS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pop_valid,
	output logic            pop_ready,
	input  rpbh_pkg::item_t pop_item,
	rpbh_cfg_if.sink        cfg,
	rpbh_rsp_if.source      rsp
);

	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW = $clog2(MAX_ROWS + 1);

	// row store
	logic signed [31:0] nx_mem [MAX_ROWS];
	logic signed [31:0] ny_mem [MAX_ROWS];
	logic signed [31:0] nz_mem [MAX_ROWS];
	logic signed [31:0] bd_mem [MAX_ROWS];

	logic [4:0]  row_count_q;
	logic [47:0] upper_q;
	logic [15:0] tol_q;

	rpbh_pkg::state_t state_q, state_d;
	rpbh_pkg::ctl_t   ctl;
	rpbh_pkg::item_t  cur_q;

	logic [CW-1:0]      row_q;
	logic [1:0]         ph_q;
	logic [1:0]         axis_q;
	logic signed [66:0] acc_q;
	logic signed [63:0] prod_q;
	logic [55:0]        a_q;
	logic [55:0]        b_q;
	logic signed [31:0] p_q [3];
	logic [47:0]        left_q;
	logic [47:0]        right_q;
	logic [47:0]        t_q;
	logic               start_in_q;

	logic               out_valid_q;
	logic               out_in_q;
	logic signed [31:0] out_x_q, out_y_q, out_z_q;
	logic [47:0]        out_t_q;

	logic [CW-1:0]      n_eff;
	logic [RW-1:0]      ridx;
	logic signed [66:0] fin;
	logic signed [31:0] nsel, psel;
	logic signed [31:0] s_sel, d_sel;
	logic [31:0]        mag;
	logic [63:0]        q;
	logic [33:0]        qr;
	logic signed [33:0] prod34, sum34;
	logic signed [31:0] adv_res;
	logic [47:0]        tol_eff;
	logic               wider;
	logic [48:0]        mid_sum;
	logic [7:0]         idx8;
	logic               is_load;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= 5'd0;
			upper_q     <= rpbh_pkg::SEARCH_UPPER_RST;
			tol_q       <= rpbh_pkg::TOLERANCE_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				rpbh_pkg::CFG_ROW_COUNT:    row_count_q <= cfg.data[4:0];
				rpbh_pkg::CFG_SEARCH_UPPER: upper_q     <= cfg.data;
				rpbh_pkg::CFG_TOLERANCE:    tol_q       <= cfg.data[15:0];
				default: ;
			endcase
		end
	end

	assign n_eff   = ({3'b0, row_count_q} > 8'(MAX_ROWS)) ? CW'(MAX_ROWS) : CW'(row_count_q);
	assign ridx    = row_q[RW-1:0];
	assign tol_eff = (tol_q == 16'd0) ? 48'd1 : {32'd0, tol_q};
	assign wider   = (right_q - left_q) > tol_eff;
	assign mid_sum = {1'b0, left_q} + {1'b0, right_q};
	assign idx8    = {4'b0, pop_item.row_index};
	assign is_load = (pop_item.op == rpbh_pkg::OP_LOAD);

	// dot product operand select
	always_comb begin
		case (ph_q)
			2'd0:    begin nsel = nx_mem[ridx]; psel = p_q[0]; end
			2'd1:    begin nsel = ny_mem[ridx]; psel = p_q[1]; end
			default: begin nsel = nz_mem[ridx]; psel = p_q[2]; end
		endcase
	end
	assign fin = acc_q + 67'(prod_q);

	// advance operand select and saturation
	always_comb begin
		case (axis_q)
			2'd0:    begin s_sel = cur_q.start_x; d_sel = cur_q.dir_x; end
			2'd1:    begin s_sel = cur_q.start_y; d_sel = cur_q.dir_y; end
			default: begin s_sel = cur_q.start_z; d_sel = cur_q.dir_z; end
		endcase
	end
	assign mag = d_sel[31] ? 32'(-d_sel) : d_sel;
	assign q   = {a_q, 8'b0} + {24'b0, b_q[55:16]};
	assign qr  = {2'b0, q[31:0]} + {33'b0, |b_q[15:0]};
	always_comb begin
		if (d_sel[31]) begin
			prod34 = (q >= 64'h8000_0000) ? -34'sh8000_0000 : -$signed(qr);
		end else begin
			prod34 = (q > 64'h7FFF_FFFF) ? 34'sh7FFF_FFFF : $signed({2'b0, q[31:0]});
		end
		sum34 = 34'(s_sel) + prod34;
		if (sum34 > 34'sh7FFF_FFFF) adv_res = 32'sh7FFF_FFFF;
		else if (sum34 < -34'sh8000_0000) adv_res = -32'sh8000_0000;
		else adv_res = sum34[31:0];
	end

	// control outputs
	always_comb begin
		ctl.test_done = ((ph_q == 2'd0) && (row_q == n_eff))
			|| ((ph_q == 2'd3) && !fin[66] && (fin != 67'sd0));
		ctl.test_in   = (ph_q == 2'd0);
		ctl.adv_done  = (axis_q == 2'd2) && (ph_q == 2'd2);
		ctl.pop_ready = (state_q == rpbh_pkg::ST_IDLE);
		ctl.out_load  = (state_q == rpbh_pkg::ST_OUT) && (!out_valid_q || rsp.ready);
	end
	assign pop_ready = ctl.pop_ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rpbh_pkg::ST_IDLE:
				if (pop_valid && !is_load) state_d = rpbh_pkg::ST_TEST_START;
			rpbh_pkg::ST_TEST_START:
				if (ctl.test_done) state_d = (cur_q.op == rpbh_pkg::OP_POINT)
					? rpbh_pkg::ST_OUT : rpbh_pkg::ST_CHECK;
			rpbh_pkg::ST_CHECK:
				state_d = wider ? rpbh_pkg::ST_ADV_MID : rpbh_pkg::ST_ADV_FIN;
			rpbh_pkg::ST_ADV_MID:
				if (ctl.adv_done) state_d = rpbh_pkg::ST_TEST_MID;
			rpbh_pkg::ST_TEST_MID:
				if (ctl.test_done) state_d = rpbh_pkg::ST_CHECK;
			rpbh_pkg::ST_ADV_FIN:
				if (ctl.adv_done) state_d = rpbh_pkg::ST_OUT;
			rpbh_pkg::ST_OUT:
				if (ctl.out_load) state_d = rpbh_pkg::ST_IDLE;
			default: state_d = rpbh_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rpbh_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.out_load) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.pop_ready && pop_valid && is_load && (idx8 < 8'(MAX_ROWS))) begin
			nx_mem[idx8[RW-1:0]] <= pop_item.normal_x;
			ny_mem[idx8[RW-1:0]] <= pop_item.normal_y;
			nz_mem[idx8[RW-1:0]] <= pop_item.normal_z;
			bd_mem[idx8[RW-1:0]] <= pop_item.bound;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			rpbh_pkg::ST_IDLE: begin
				cur_q  <= pop_item;
				p_q[0] <= pop_item.start_x;
				p_q[1] <= pop_item.start_y;
				p_q[2] <= pop_item.start_z;
				row_q  <= '0;
				ph_q   <= 2'd0;
			end
			rpbh_pkg::ST_TEST_START, rpbh_pkg::ST_TEST_MID: begin
				if (ctl.test_done) begin
					if (state_q == rpbh_pkg::ST_TEST_START) begin
						start_in_q <= ctl.test_in;
						left_q     <= 48'd0;
						right_q    <= upper_q;
					end else if (ctl.test_in) begin
						left_q <= t_q;
					end else begin
						right_q <= t_q;
					end
				end else begin
					prod_q <= nsel * psel;
					case (ph_q)
						2'd0:    acc_q <= -$signed({{19{bd_mem[ridx][31]}}, bd_mem[ridx], 16'b0});
						2'd3:    acc_q <= acc_q;
						default: acc_q <= fin;
					endcase
					ph_q <= ph_q + 2'd1;
					if (ph_q == 2'd3) row_q <= row_q + CW'(1);
				end
			end
			rpbh_pkg::ST_CHECK: begin
				t_q    <= wider ? mid_sum[48:1] : left_q;
				axis_q <= 2'd0;
				ph_q   <= 2'd0;
			end
			rpbh_pkg::ST_ADV_MID, rpbh_pkg::ST_ADV_FIN: begin
				case (ph_q)
					2'd0: begin a_q <= mag * t_q[47:24]; ph_q <= 2'd1; end
					2'd1: begin b_q <= mag * t_q[23:0]; ph_q <= 2'd2; end
					default: begin
						p_q[axis_q] <= adv_res;
						axis_q      <= axis_q + 2'd1;
						ph_q        <= 2'd0;
					end
				endcase
				row_q <= '0;
			end
			rpbh_pkg::ST_OUT: begin
				if (ctl.out_load) begin
					out_in_q <= start_in_q;
					if (cur_q.op == rpbh_pkg::OP_RAY) begin
						out_x_q <= p_q[0];
						out_y_q <= p_q[1];
						out_z_q <= p_q[2];
						out_t_q <= t_q;
					end else begin
						out_x_q <= 32'sd0;
						out_y_q <= 32'sd0;
						out_z_q <= 32'sd0;
						out_t_q <= 48'd0;
					end
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.inside_res = out_in_q;
	assign rsp.hit_x      = out_x_q;
	assign rsp.hit_y      = out_y_q;
	assign rsp.hit_z      = out_z_q;
	assign rsp.hit_param  = out_t_q;

endmodule

>>> rtl/core/ray_polytope_bisection_hit.sv
// ray hit against a convex polytope stored as half-space rows
// req channel carries one item per beat: op selects a row load, a point
//   test or a ray query; the other fields are the row and the ray
// rsp channel returns one beat per point test or ray query, none for loads
// cfg channel writes row_count, search_upper and tolerance; take it only
//   while the block is idle
// a front stage takes req beats, drops the unused op and feeds a
//   two-entry queue; the back engine drains it one item at a time
// steps: a point test checks rows in turn, one product per step, until
//   all pass or one rejects the point; a ray query tests the start, then
//   bisects [0, search_upper] over about log2(search_upper / tolerance)
//   steps, testing each advanced midpoint; the hit is the left end
// throughput: one item at a time in the back engine, the queue keeps
//   taking beats while it works, until both of its entries are full
// reset clears control state and config registers to their reset values;
//   row contents are undefined until loaded
// a stalled rsp holds its beat; the engine waits at the result register
module ray_polytope_bisection_hit #(
	parameter int MAX_ROWS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	rpbh_req_if.sink    req,
	rpbh_cfg_if.sink    cfg,
	rpbh_rsp_if.source  rsp
);

	// front to queue
	logic            push_valid;
	logic            push_ready;
	rpbh_pkg::item_t push_item;

	// queue to back engine
	logic            pop_valid;
	logic            pop_ready;
	rpbh_pkg::item_t pop_item;

	rpbh_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	rpbh_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	// bisection engine with the row store and config registers
	rpbh_back #(
		.MAX_ROWS (MAX_ROWS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item),
		.cfg       (cfg),
		.rsp       (rsp)
	);

endmodule
